>>> rtl/sgb_pkg.sv
// Shared constants, payload types and the Gaussian weight table of the blur.
// Used by every file under rtl; depends on nothing.
package sgb_pkg;

	localparam int MAX_WIDTH        = 2048;
	localparam int MAX_SIGMA        = 2;
	localparam int WEIGHT_BITS      = 16;
	localparam int TABLE_SIGMAS     = 2;
	localparam int RADIUS_PER_SIGMA = 3;
	localparam int MAX_RADIUS       = RADIUS_PER_SIGMA * MAX_SIGMA;
	localparam int STORE_ROWS       = 2 * MAX_RADIUS;
	localparam int TAPS             = 2 * MAX_RADIUS + 1;
	localparam int HALF             = MAX_RADIUS + 1;
	localparam int TABLE_LEN        = 7;

	localparam int COL_BITS  = $clog2(MAX_WIDTH);
	localparam int WID_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_BITS  = 17;
	localparam int SLOT_BITS = $clog2(STORE_ROWS);
	localparam int SPAN_BITS = $clog2(STORE_ROWS + 1);
	localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
	localparam int DSEL_BITS = $clog2(TAPS);
	localparam int LAG_BITS  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
	localparam cfg_idx_t REG_SIGMA        = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// red in the low byte, blue in the high byte
	typedef logic [23:0] pix_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_word_t;

	// half kernels in Q0.16, centre outward, sigma 1 then sigma 2
	localparam logic [15:0] HALF_KERNEL [TABLE_SIGMAS][TABLE_LEN] = '{
		'{16'd26152, 16'd15862, 16'd3539, 16'd291, 16'd0, 16'd0, 16'd0},
		'{16'd13086, 16'd11548, 16'd7937, 16'd4248, 16'd1771, 16'd575, 16'd145}
	};

	// weight at distance d from the centre; zero past the radius of sigma
	function automatic logic [WEIGHT_BITS-1:0] kernel_weight(input logic sidx, input int d);
		logic [31:0] w;
		w = '0;
		if (d <= RADIUS_PER_SIGMA * (int'(sidx) + 1) && d < TABLE_LEN) begin
			w = {16'd0, HALF_KERNEL[sidx][d]};
			if (WEIGHT_BITS >= 16)
				w = w << (WEIGHT_BITS - 16);
			else
				w = (w + (32'd1 << (15 - WEIGHT_BITS))) >> (16 - WEIGHT_BITS);
		end
		return w[WEIGHT_BITS-1:0];
	endfunction

endpackage

>>> rtl/sgb_line_ram.sv
// One line buffer: a row of RGB pixels, one write and one registered read a cycle.
// Depends on sgb_pkg.
module sgb_line_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [sgb_pkg::COL_BITS-1:0] waddr,
	input  sgb_pkg::pix_t                wdata,
	input  logic                         re,
	input  logic [sgb_pkg::COL_BITS-1:0] raddr,
	output sgb_pkg::pix_t                rdata
);
	import sgb_pkg::*;

	pix_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

>>> rtl/sgb_pass.sv
// One blur pass over TAPS RGB samples: fold symmetric taps, one multiplier lane per
// distance and channel, then a registered adder tree with truncate and saturate.
// Four register stages; depends on sgb_pkg.
module sgb_pass (
	input  logic          clk,
	input  logic          en,
	input  logic          sidx,
	input  sgb_pkg::pix_t taps [sgb_pkg::TAPS],
	output sgb_pkg::pix_t result
);
	import sgb_pkg::*;

	localparam int PROD_BITS = 9 + WEIGHT_BITS;
	localparam int ACC_BITS  = PROD_BITS + $clog2(HALF + 1);
	localparam int LO_COUNT  = (HALF + 1) / 2;

	logic [8:0]           fold_d [3][HALF];
	logic [8:0]           fold_s1 [3][HALF];
	logic [PROD_BITS-1:0] prod_d [3][HALF];
	logic [PROD_BITS-1:0] prod_s2 [3][HALF];
	logic [ACC_BITS-1:0]  part_d [3][2];
	logic [ACC_BITS-1:0]  part_s3 [3][2];
	pix_t                 res_d;
	pix_t                 res_s4;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int d = 0; d < HALF; d++) begin
				if (d == 0)
					fold_d[ch][d] = {1'b0, taps[MAX_RADIUS][8*ch +: 8]};
				else
					fold_d[ch][d] = {1'b0, taps[MAX_RADIUS+d][8*ch +: 8]}
						+ {1'b0, taps[MAX_RADIUS-d][8*ch +: 8]};
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++)
			for (int d = 0; d < HALF; d++)
				prod_d[ch][d] = PROD_BITS'(fold_s1[ch][d])
					* PROD_BITS'(kernel_weight(sidx, d));
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			part_d[ch][0] = '0;
			part_d[ch][1] = '0;
			for (int d = 0; d < HALF; d++) begin
				if (d < LO_COUNT)
					part_d[ch][0] = part_d[ch][0] + ACC_BITS'(prod_s2[ch][d]);
				else
					part_d[ch][1] = part_d[ch][1] + ACC_BITS'(prod_s2[ch][d]);
			end
		end
	end

	always_comb begin
		logic [ACC_BITS-1:0] total;
		logic [ACC_BITS-1:0] v;
		res_d = '0;
		for (int ch = 0; ch < 3; ch++) begin
			total = part_s3[ch][0] + part_s3[ch][1];
			v = total >> WEIGHT_BITS;
			res_d[8*ch +: 8] = (v > ACC_BITS'(255)) ? 8'hFF : v[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= fold_d;
			prod_s2 <= prod_d;
			part_s3 <= part_d;
			res_s4  <= res_d;
		end
	end

	assign result = res_s4;

endmodule

>>> rtl/separable_gaussian_blur_rgb_top.sv
// Separable Gaussian blur on an RGB raster stream, one word accepted per clock when the
// output is not stalled; a result for pixel p comes out on the word radius rows plus
// radius pixels later (radius = 3*sigma), so radius*width + radius flush words drain
// a frame. The rate is set by one registered read per line buffer and pipelined
// multiplier lanes, so it is one word per cycle throughout, stalls of the output apart.
// Twelve line buffers of 2048 pixels hold the rows of the vertical pass; they are not
// cleared after reset and every read is of a written row. A flush inside the frame is
// dropped; a pixel past the frame end is a flush. Writes to the three configuration
// registers restart the frame. Depends on sgb_pkg, sgb_line_ram, sgb_pass.
module separable_gaussian_blur_rgb_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  sgb_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  sgb_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sgb_pkg::out_word_t out_data
);
	import sgb_pkg::*;

	typedef struct packed {
		logic                                emit;
		logic                                last;
		logic [TAPS-1:0][DSEL_BITS-1:0]      dsel;
	} ctl_t;

	typedef struct packed {
		logic [TAPS-1:0]                     use_cur;
		logic [TAPS-1:0][SLOT_BITS-1:0]      slot;
	} vsel_t;

	logic [11:0] width_q;
	logic [15:0] height_q;
	logic [1:0]  sigma_q;

	logic [ROW_BITS-1:0]  in_row_q;
	logic [COL_BITS-1:0]  in_col_q;
	logic [SLOT_BITS-1:0] m_q;
	logic [SLOT_BITS-1:0] last_slot_q;
	logic [15:0]          orow_q;
	logic [COL_BITS-1:0]  ocol_q;
	logic [LAG_BITS-1:0]  lag_cnt_q;

	logic [WID_BITS-1:0]  w_eff;
	logic [15:0]          h_eff;
	logic                 sidx;
	logic [RAD_BITS-1:0]  r;
	logic [SPAN_BITS-1:0] span;
	logic [LAG_BITS-1:0]  lag;

	logic in_frame, ignore, go, emit, last, col_wrap, ocol_wrap, en;
	ctl_t  ctl_d;
	vsel_t vsel_d;
	pix_t  cur_d;

	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10;
	vsel_t vsel_s1;
	pix_t  cur_s1;

	pix_t rd [STORE_ROWS];
	pix_t vtaps [TAPS];
	pix_t htaps [TAPS];
	pix_t vres, hres;
	pix_t hw_q [TAPS];

	// effective configuration
	always_comb begin
		if (width_q == '0)
			w_eff = WID_BITS'(1);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = WID_BITS'(MAX_WIDTH);
		else
			w_eff = WID_BITS'(width_q);
		h_eff = (height_q == '0) ? 16'd1 : height_q;
		sidx  = (sigma_q >= 2'd2) && (MAX_SIGMA >= 2) && (TABLE_SIGMAS >= 2);
		r     = sidx ? RAD_BITS'(2 * RADIUS_PER_SIGMA) : RAD_BITS'(RADIUS_PER_SIGMA);
		span  = SPAN_BITS'(2 * int'(r));
		lag   = LAG_BITS'(r) * LAG_BITS'(w_eff) + LAG_BITS'(r);
	end

	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign in_frame  = in_row_q < ROW_BITS'(h_eff);
	assign ignore    = in_frame && (in_data.op == OP_FLUSH);
	assign go        = in_valid && in_ready && !ignore;
	// words counted since the frame start, held once the lag is reached
	assign emit      = lag_cnt_q >= lag;
	assign last      = emit && (orow_q == h_eff - 16'd1)
		&& (WID_BITS'(ocol_q) == w_eff - WID_BITS'(1));
	assign col_wrap  = (WID_BITS'(in_col_q) + WID_BITS'(1)) == w_eff;
	assign ocol_wrap = (WID_BITS'(ocol_q) + WID_BITS'(1)) == w_eff;
	assign cur_d     = in_frame ? {in_data.blue_in, in_data.green_in, in_data.red_in} : '0;

	// tap selection for both passes, worked out on the accepted word
	always_comb begin
		logic signed [ROW_BITS+1:0] xs;
		logic signed [7:0]          sv;
		logic signed [WID_BITS+1:0] c;
		logic signed [WID_BITS+1:0] dv;
		int o;
		vsel_d = '0;
		ctl_d  = '0;
		ctl_d.emit = emit;
		ctl_d.last = last;
		for (int k = 0; k < TAPS; k++) begin
			o = k - MAX_RADIUS;
			xs = $signed({2'b00, in_row_q}) - $signed((ROW_BITS+2)'(r)) + (ROW_BITS+2)'(o);
			sv = $signed(8'(m_q)) + $signed(8'(span)) + 8'(o) - $signed(8'(r));
			if (sv >= $signed(8'(span)))
				sv = sv - $signed(8'(span));
			if (o > int'(r) || -o > int'(r)) begin
				vsel_d.use_cur[k] = 1'b1;
				vsel_d.slot[k]    = '0;
			end else if (xs < 0) begin
				vsel_d.use_cur[k] = in_frame && (in_row_q == '0);
				vsel_d.slot[k]    = '0;
			end else if (xs >= $signed((ROW_BITS+2)'(h_eff))) begin
				vsel_d.use_cur[k] = 1'b0;
				vsel_d.slot[k]    = last_slot_q;
			end else begin
				vsel_d.use_cur[k] = in_frame && (o == int'(r));
				vsel_d.slot[k]    = SLOT_BITS'(sv);
			end

			c = $signed((WID_BITS+2)'(ocol_q)) + (WID_BITS+2)'(o);
			if (o > int'(r) || -o > int'(r))
				dv = '0;
			else if (c < 0)
				dv = $signed((WID_BITS+2)'(ocol_q)) + $signed((WID_BITS+2)'(r));
			else if (c >= $signed((WID_BITS+2)'(w_eff)))
				dv = $signed((WID_BITS+2)'(ocol_q)) + $signed((WID_BITS+2)'(r))
					+ (WID_BITS+2)'(1) - $signed((WID_BITS+2)'(w_eff));
			else
				dv = $signed((WID_BITS+2)'(r)) - (WID_BITS+2)'(o);
			if (dv > (WID_BITS+2)'(TAPS - 1))
				dv = (WID_BITS+2)'(TAPS - 1);
			ctl_d.dsel[k] = DSEL_BITS'(dv);
		end
	end

	// configuration and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 12'd640;
			height_q    <= 16'd480;
			sigma_q     <= 2'd1;
			in_row_q    <= '0;
			in_col_q    <= '0;
			m_q         <= '0;
			last_slot_q <= '0;
			orow_q      <= '0;
			ocol_q      <= '0;
			lag_cnt_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata[11:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				REG_SIGMA:        sigma_q  <= cfg_wdata[1:0];
				default:          ;
			endcase
			if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
					|| cfg_index == REG_SIGMA) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				m_q       <= '0;
				orow_q    <= '0;
				ocol_q    <= '0;
				lag_cnt_q <= '0;
			end
		end else if (go) begin
			if (in_frame && in_row_q == ROW_BITS'(h_eff) - ROW_BITS'(1))
				last_slot_q <= m_q;
			if (last) begin
				in_row_q  <= '0;
				in_col_q  <= '0;
				m_q       <= '0;
				orow_q    <= '0;
				ocol_q    <= '0;
				lag_cnt_q <= '0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_BITS'(1);
					m_q <= (SPAN_BITS'(m_q) + SPAN_BITS'(1) == span) ? '0 : m_q + SLOT_BITS'(1);
				end else begin
					in_col_q <= in_col_q + COL_BITS'(1);
				end
				if (emit) begin
					if (ocol_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + 16'd1;
					end else begin
						ocol_q <= ocol_q + COL_BITS'(1);
					end
				end else begin
					lag_cnt_q <= lag_cnt_q + LAG_BITS'(1);
				end
			end
		end
	end

	// line buffers: one per row slot, all read at the current column
	for (genvar i = 0; i < STORE_ROWS; i++) begin : g_line
		sgb_line_ram u_ram (
			.clk   (clk),
			.we    (go && in_frame && m_q == SLOT_BITS'(i)),
			.waddr (in_col_q),
			.wdata (cur_d),
			.re    (go),
			.raddr (in_col_q),
			.rdata (rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10}
				<= {go, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1  <= ctl_d;
			vsel_s1 <= vsel_d;
			cur_s1  <= cur_d;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
		end
	end

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			if (vsel_s1.use_cur[k])
				vtaps[k] = cur_s1;
			else if (32'(vsel_s1.slot[k]) < STORE_ROWS)
				vtaps[k] = rd[vsel_s1.slot[k]];
			else
				vtaps[k] = '0;
		end
	end

	sgb_pass u_vpass (
		.clk    (clk),
		.en     (en),
		.sidx   (sidx),
		.taps   (vtaps),
		.result (vres)
	);

	// shift each vertical result into the horizontal window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '{default: '0};
		end else if (en && v_s5) begin
			hw_q[0] <= vres;
			for (int i = 1; i < TAPS; i++)
				hw_q[i] <= hw_q[i-1];
		end
	end

	always_comb begin
		for (int k = 0; k < TAPS; k++)
			htaps[k] = hw_q[ctl_s6.dsel[k]];
	end

	sgb_pass u_hpass (
		.clk    (clk),
		.en     (en),
		.sidx   (sidx),
		.taps   (htaps),
		.result (hres)
	);

	assign out_valid = v_s10 && ctl_s10.emit;
	assign out_data  = '{red_out: hres[7:0], green_out: hres[15:8], blue_out: hres[23:16],
		frame_last: ctl_s10.last};

endmodule

>>> rtl/sgb_checker.sv
// Port-level checks on the blur top level, attached by the bind at the end.
// Depends on sgb_pkg and separable_gaussian_blur_rgb_top.
module sgb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input sgb_pkg::cfg_idx_t  cfg_index,
	input logic [15:0]        cfg_wdata,
	input logic               in_valid,
	input logic               in_ready,
	input sgb_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input sgb_pkg::out_word_t out_data
);
	import sgb_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// a waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// input side advances exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// write registers only with no result waiting
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !out_valid && !$isunknown({cfg_index, cfg_wdata}))
		else $error("register write while a result is waiting");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result word during reset");

endmodule

bind separable_gaussian_blur_rgb_top sgb_checker u_sgb_checker (.*);
